// File: rtl/chrl_pkg.sv
// ---------------------------------------------------------------------------
// chrl_pkg: shared types and constants for the hash ring lookup core
// MurmurHash2 constants, opcodes and the sequencer state type.
// ---------------------------------------------------------------------------
package chrl_pkg;

    localparam logic [31:0] MM_MUL  = 32'h5bd1e995;
    localparam logic [31:0] MM_SEED = 32'h4d4d4832;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam logic [1:0] CFG_RING_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_TARGET_COUNT = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_FIN1,
        ST_FIN2,
        ST_SRCH,
        ST_SRCH_WAIT,
        ST_WALK,
        ST_WALK_WAIT,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/chrl_ram.sv
// ---------------------------------------------------------------------------
// chrl_ram: generic single port ram
// One access a cycle: a write also reads the old word; read data registered.
// ---------------------------------------------------------------------------
module chrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/consistent_hash_ring_lookup_core.sv
// ---------------------------------------------------------------------------
// consistent_hash_ring_lookup_core
// Loads a sorted ring of (hash, target) points into a ram, hashes streamed
// keys with MurmurHash2 and walks the ring to emit distinct targets.
// ---------------------------------------------------------------------------
// load request: written as accepted. key chunk: ST_MIX1, ST_MIX2 (two
// registered multiplies). last chunk: also ST_FIN1, ST_FIN2, then ST_SRCH and
// ST_SRCH_WAIT per binary search step (up to log2 of ring_entries + 1 steps,
// plus an exit ST_SRCH), ST_WALK and ST_WALK_WAIT per ring point walked,
// ST_EMIT per result, and a re-read of each new target met while one is held.
// synchronous active-low reset clears control, accumulator, config and m_valid;
// ring contents stay undefined until loaded.
module consistent_hash_ring_lookup_core #(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_TARGETS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [11:0] s_entry_index,
    input  logic [31:0] s_entry_hash,
    input  logic [3:0]  s_entry_target,
    input  logic [31:0] s_key_word,
    input  logic [2:0]  s_key_bytes,
    input  logic [15:0] s_key_length,
    input  logic        s_key_first,
    input  logic        s_key_last,
    input  logic [4:0]  s_want_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_target,
    output logic [4:0]  m_rank,
    output logic [31:0] m_key_hash,
    output logic        m_status,
    output logic        m_last
);
    import chrl_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int NW = AW + 1;
    localparam int TW = $clog2(MAX_TARGETS + 1);

    state_t state_reg, state_next;

    logic [12:0]   ring_entries_reg;
    logic [4:0]    target_count_reg;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   k_reg, k_next;
    logic [31:0]   h_reg, h_next;
    logic [2:0]    nb_reg, nb_next;
    logic [31:0]   w_reg, w_next;
    logic          lastc_reg, lastc_next;
    logic [4:0]    want_reg, want_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [NW-1:0] pos_reg, pos_next, step_reg, step_next;
    logic [15:0]   seen_reg, seen_next;
    logic [4:0]    rank_reg, rank_next;
    logic          cand_reg, cand_next;
    logic [3:0]    cand_tgt_reg, cand_tgt_next;
    logic          em_stat_reg, em_stat_next, em_last_reg, em_last_next;
    logic [3:0]    o_tgt_reg, o_tgt_next;
    logic [4:0]    o_rank_reg, o_rank_next;
    logic [31:0]   o_hash_reg, o_hash_next;
    logic          o_stat_reg, o_stat_next, o_last_reg, o_last_next;
    logic          m_valid_reg, m_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_hash;
    logic [3:0]    ram_tgt;
    logic [NW-1:0] mid;
    logic [NW-1:0] n_sat;
    logic [TW-1:0] tc_sat;
    logic [4:0]    want_cl;
    logic [NW-1:0] pos_inc;
    logic          walk_done;

    chrl_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_hash_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_entry_hash), .rdata(ram_hash)
    );
    chrl_ram #(.WIDTH(4), .DEPTH(RING_DEPTH)) u_tgt_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_entry_target), .rdata(ram_tgt)
    );

    // register saturation and want count clamp
    always_comb begin
        if (32'(ring_entries_reg) > RING_DEPTH) n_sat = NW'(RING_DEPTH);
        else n_sat = NW'(ring_entries_reg);
        if (32'(target_count_reg) > MAX_TARGETS) tc_sat = TW'(MAX_TARGETS);
        else tc_sat = TW'(target_count_reg);
        want_cl = s_want_count;
        if (want_cl == 5'd0) want_cl = 5'd1;
        if (32'(want_cl) > 32'(tc_sat)) want_cl = 5'(tc_sat);
    end

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_inc = (pos_reg + 1'b1 >= n_reg) ? '0 : pos_reg + 1'b1;
    assign s_ready = (state_reg == ST_IDLE);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_entries_reg <= '0;
            target_count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RING_ENTRIES: ring_entries_reg <= cfg_data;
                CFG_TARGET_COUNT: target_count_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            seen_reg    <= '0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            seen_reg    <= seen_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg <= k_next; h_reg <= h_next; nb_reg <= nb_next; w_reg <= w_next;
        lastc_reg <= lastc_next; want_reg <= want_next; n_reg <= n_next;
        lo_reg <= lo_next; hi_reg <= hi_next; pos_reg <= pos_next;
        step_reg <= step_next; o_tgt_reg <= o_tgt_next;
        o_stat_reg <= o_stat_next; o_last_reg <= o_last_next;
        o_rank_reg <= o_rank_next; o_hash_reg <= o_hash_next;
        cand_reg <= cand_next; cand_tgt_reg <= cand_tgt_next;
        em_stat_reg <= em_stat_next; em_last_reg <= em_last_next;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        acc_next = acc_reg; k_next = k_reg; h_next = h_reg; nb_next = nb_reg;
        w_next = w_reg; lastc_next = lastc_reg; want_next = want_reg;
        n_next = n_reg; lo_next = lo_reg; hi_next = hi_reg; pos_next = pos_reg;
        step_next = step_reg; seen_next = seen_reg; rank_next = rank_reg;
        cand_next = cand_reg; cand_tgt_next = cand_tgt_reg;
        em_stat_next = em_stat_reg; em_last_next = em_last_reg;
        o_tgt_next = o_tgt_reg; o_stat_next = o_stat_reg; o_last_next = o_last_reg;
        o_rank_next = o_rank_reg; o_hash_next = o_hash_reg;
        m_valid_next = m_valid_reg;
        ram_we = 1'b0;
        ram_addr = mid[AW-1:0];
        walk_done = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                ram_addr = s_entry_index[AW-1:0];
                if (s_valid && s_ready) begin
                    if (s_opcode == OP_LOAD) begin
                        ram_we = (32'(s_entry_index) < RING_DEPTH);
                    end else begin
                        h_next = s_key_first ? (MM_SEED ^ 32'(s_key_length)) : acc_reg;
                        w_next = s_key_word;
                        nb_next = s_key_bytes;
                        lastc_next = s_key_last;
                        want_next = want_cl;
                        n_next = n_sat;
                        k_next = s_key_word * MM_MUL;
                        state_next = ST_MIX1;
                    end
                end
            end
            ST_MIX1: begin
                if (nb_reg >= 3'd4) begin
                    k_next = (k_reg ^ (k_reg >> 24)) * MM_MUL;
                    h_next = h_reg * MM_MUL;
                end else if (nb_reg != 3'd0) begin
                    h_next = (h_reg ^ (w_reg & ((32'd1 << {nb_reg, 3'b000}) - 32'd1)))
                             * MM_MUL;
                    k_next = '0;
                end else begin
                    k_next = '0;
                end
                state_next = ST_MIX2;
            end
            ST_MIX2: begin
                h_next = h_reg ^ k_reg;
                acc_next = h_reg ^ k_reg;
                state_next = lastc_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                h_next = (h_reg ^ (h_reg >> 13)) * MM_MUL;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                h_next = h_reg ^ (h_reg >> 15);
                seen_next = '0;
                rank_next = '0;
                cand_next = 1'b0;
                lo_next = '0;
                hi_next = n_reg;
                step_next = '0;
                if (n_reg == '0 || tc_sat == '0) begin
                    em_stat_next = 1'b1;
                    em_last_next = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (lo_reg < hi_reg) state_next = ST_SRCH_WAIT;
                else begin
                    pos_next = (lo_reg >= n_reg) ? '0 : lo_reg;
                    state_next = ST_WALK;
                end
            end
            ST_SRCH_WAIT: begin
                if (ram_hash < h_reg) lo_next = mid + 1'b1;
                else hi_next = mid;
                state_next = ST_SRCH;
            end
            ST_WALK: begin
                ram_addr = pos_reg[AW-1:0];
                state_next = ST_WALK_WAIT;
            end
            ST_WALK_WAIT: begin
                ram_addr = pos_reg[AW-1:0];
                walk_done = (step_reg + 1'b1 >= n_reg);
                if (!seen_reg[ram_tgt] && cand_reg) begin
                    // release the held target first, then read this point again
                    cand_next = 1'b0;
                    em_stat_next = 1'b0;
                    em_last_next = 1'b0;
                    state_next = ST_EMIT;
                end else begin
                    pos_next = pos_inc;
                    step_next = step_reg + 1'b1;
                    if (!seen_reg[ram_tgt]) begin
                        // hold the new target until the next one or the end is known
                        seen_next = seen_reg | (16'd1 << ram_tgt);
                        rank_next = rank_reg + 1'b1;
                        cand_next = 1'b1;
                        cand_tgt_next = ram_tgt;
                        if (walk_done || (rank_reg + 1'b1 >= want_reg)) begin
                            em_stat_next = 1'b0;
                            em_last_next = 1'b1;
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_WALK;
                        end
                    end else if (walk_done) begin
                        // lap over, the held target is the final one
                        em_stat_next = 1'b0;
                        em_last_next = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_EMIT: begin
                // load the result registers once the previous result is gone
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_tgt_next = em_stat_reg ? 4'd0 : cand_tgt_reg;
                    o_rank_next = em_stat_reg ? 5'd0 : rank_reg;
                    o_hash_next = h_reg;
                    o_stat_next = em_stat_reg;
                    o_last_next = em_last_reg;
                    state_next = em_last_reg ? ST_IDLE : ST_WALK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_target   = o_tgt_reg;
    assign m_rank     = o_rank_reg;
    assign m_key_hash = o_hash_reg;
    assign m_status   = o_stat_reg;
    assign m_last     = o_last_reg;

    // output holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_target) && $stable(m_rank))
        else $error("result changed while stalled");
    // no request taken while busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("ready while busy");
    // rank stays within the target range
    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> 32'(m_rank) <= MAX_TARGETS && m_rank != 5'd0)
        else $error("rank out of range");
endmodule

// File: tb/ring_lookup_checker.sv
// ---------------------------------------------------------------------------
// ring_lookup_checker
// Watches the config port, request and result channels of the ring lookup
// core, keeps its own ring copy and MurmurHash2 accumulator, predicts every
// lookup result and compares the results that come out, in order.
// ---------------------------------------------------------------------------
module ring_lookup_checker #(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_TARGETS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [11:0] s_entry_index,
    input  logic [31:0] s_entry_hash,
    input  logic [3:0]  s_entry_target,
    input  logic [31:0] s_key_word,
    input  logic [2:0]  s_key_bytes,
    input  logic [15:0] s_key_length,
    input  logic        s_key_first,
    input  logic        s_key_last,
    input  logic [4:0]  s_want_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_target,
    input  logic [4:0]  m_rank,
    input  logic [31:0] m_key_hash,
    input  logic        m_status,
    input  logic        m_last,
    output int          fail_count,
    output int          pending
);
    import chrl_pkg::*;

    typedef struct {
        logic [3:0]  target;
        logic [4:0]  rank;
        logic [31:0] key_hash;
        logic        status;
        logic        last;
    } ring_pick_t;

    logic [31:0] ring_hash [RING_DEPTH];
    logic [3:0]  ring_owner [RING_DEPTH];
    logic [31:0] hash_acc;
    logic [12:0] ring_entries;
    logic [4:0]  target_count;
    ring_pick_t  picks_q [$];
    int          errs;

    // update ring or hash state for one request, queue the targets it selects
    task automatic absorb_request();
        logic [31:0] h;
        logic [31:0] k;
        logic [15:0] seen;
        int unsigned n, tc, want, lo, hi, mid, pos, step, rank;
        ring_pick_t  p;
        if (s_opcode == OP_LOAD) begin
            ring_hash[s_entry_index]  = s_entry_hash;
            ring_owner[s_entry_index] = s_entry_target;
            return;
        end
        if (s_key_first)
            hash_acc = MM_SEED ^ {16'h0, s_key_length};
        h = hash_acc;
        if (s_key_bytes >= 3'd4) begin
            k = s_key_word * MM_MUL;
            k = k ^ (k >> 24);
            k = k * MM_MUL;
            h = h * MM_MUL;
            h = h ^ k;
        end else if (s_key_bytes != 3'd0) begin
            h = h ^ (s_key_word & ((32'h1 << (8 * s_key_bytes)) - 32'h1));
            h = h * MM_MUL;
        end
        hash_acc = h;
        if (!s_key_last)
            return;
        // finalize
        h = h ^ (h >> 13);
        h = h * MM_MUL;
        h = h ^ (h >> 15);
        n  = (ring_entries > RING_DEPTH) ? RING_DEPTH : ring_entries;
        tc = (target_count > MAX_TARGETS) ? MAX_TARGETS : target_count;
        if (n == 0 || tc == 0) begin
            p = '{target: 4'd0, rank: 5'd0, key_hash: h, status: 1'b1, last: 1'b1};
            picks_q.push_back(p);
            return;
        end
        want = s_want_count;
        if (want < 1)
            want = 1;
        if (want > tc)
            want = tc;
        // lower bound search
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (ring_hash[mid] < h)
                lo = mid + 1;
            else
                hi = mid;
        end
        pos  = (lo >= n) ? 0 : lo;
        seen = '0;
        rank = 0;
        // walk with wrap, one lap at most
        for (step = 0; step < n && rank < want; step++) begin
            if (!seen[ring_owner[pos]]) begin
                seen[ring_owner[pos]] = 1'b1;
                rank++;
                p = '{target: ring_owner[pos], rank: 5'(rank), key_hash: h,
                      status: 1'b0, last: 1'b0};
                picks_q.push_back(p);
            end
            pos = (pos + 1 >= n) ? 0 : pos + 1;
        end
        picks_q[picks_q.size() - 1].last = 1'b1;
    endtask

    // compare one result against the oldest prediction
    task automatic compare_result();
        ring_pick_t p;
        if (picks_q.size() == 0) begin
            $error("unexpected result: target %0d rank %0d hash %h", m_target, m_rank,
                   m_key_hash);
            errs++;
            return;
        end
        p = picks_q.pop_front();
        if (m_target !== p.target) begin
            $error("target: expected %0d actual %0d", p.target, m_target);
            errs++;
        end
        if (m_rank !== p.rank) begin
            $error("rank: expected %0d actual %0d", p.rank, m_rank);
            errs++;
        end
        if (m_key_hash !== p.key_hash) begin
            $error("key_hash: expected %h actual %h", p.key_hash, m_key_hash);
            errs++;
        end
        if (m_status !== p.status) begin
            $error("status: expected %0d actual %0d", p.status, m_status);
            errs++;
        end
        if (m_last !== p.last) begin
            $error("last: expected %0d actual %0d", p.last, m_last);
            errs++;
        end
    endtask

    // sample everything at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            hash_acc     = '0;
            ring_entries = '0;
            target_count = '0;
            picks_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_RING_ENTRIES)
                    ring_entries = cfg_data;
                else if (cfg_index == CFG_TARGET_COUNT)
                    target_count = cfg_data[4:0];
            end
            if (s_valid && s_ready)
                absorb_request();
            if (m_valid && m_ready)
                compare_result();
        end
        pending    <= picks_q.size();
        fail_count <= errs;
    end

    initial errs = 0;

endmodule

// File: tb/consistent_hash_ring_lookup_core_tb.sv
// ---------------------------------------------------------------------------
// consistent_hash_ring_lookup_core_tb
// Loads sorted rings of several sizes, streams keys of various lengths and
// chunk shapes, and lets the checker verify hash, targets, ranks and flags
// under random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module consistent_hash_ring_lookup_core_tb;
    import chrl_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int MAX_TARGETS = 16;
    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [1:0]  cfg_index      = '0;
    logic [12:0] cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_opcode       = OP_LOAD;
    logic [11:0] s_entry_index  = '0;
    logic [31:0] s_entry_hash   = '0;
    logic [3:0]  s_entry_target = '0;
    logic [31:0] s_key_word     = '0;
    logic [2:0]  s_key_bytes    = '0;
    logic [15:0] s_key_length   = '0;
    logic        s_key_first    = 1'b0;
    logic        s_key_last     = 1'b0;
    logic [4:0]  s_want_count   = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [3:0]  m_target;
    logic [4:0]  m_rank;
    logic [31:0] m_key_hash;
    logic        m_status;
    logic        m_last;

    int fail_count;
    int pending;
    int burst_left = 0;
    int hold_seq   = 0;
    int ring_size  = 0;
    int cycles     = 0;

    consistent_hash_ring_lookup_core #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TARGETS(MAX_TARGETS)
    ) uut (.*);

    ring_lookup_checker #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TARGETS(MAX_TARGETS)
    ) checker_i (.*);

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: stall pattern re-drawn on a tick counter, plus requested long holds
    initial begin : receiver
        int hold_done;
        int stall_mode;
        int tick;
        hold_done  = 0;
        stall_mode = 0;
        tick       = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_done) begin
                hold_done = hold_seq;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                tick++;
                if (tick % 100 == 0)
                    stall_mode = $urandom_range(0, 2);
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one request, with bursts and gaps, and wait until it is taken
    task automatic send_request(logic op, logic [11:0] idx, logic [31:0] hsh,
                                logic [3:0] tgt, logic [31:0] word, logic [2:0] nb,
                                logic [15:0] len, logic first, logic last,
                                logic [4:0] want);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_entry_index  <= idx;
        s_entry_hash   <= hsh;
        s_entry_target <= tgt;
        s_key_word     <= word;
        s_key_bytes    <= nb;
        s_key_length   <= len;
        s_key_first    <= first;
        s_key_last     <= last;
        s_want_count   <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_entry(int idx, logic [31:0] hsh, logic [3:0] tgt);
        send_request(OP_LOAD, 12'(idx), hsh, tgt, $urandom, 3'($urandom),
                     16'($urandom), 1'($urandom), 1'($urandom), 5'($urandom));
    endtask

    // stream a key of nbytes bytes; len_field goes in every chunk, used on the first
    task automatic send_key(int nbytes, logic [15:0] len_field, logic [4:0] want);
        int off;
        int rem;
        for (off = 0; off < nbytes; off += 4) begin
            rem = nbytes - off;
            send_request(OP_KEY, 12'($urandom), $urandom, 4'($urandom), $urandom,
                         3'((rem > 4) ? 4 : rem), len_field, off == 0, rem <= 4, want);
        end
    endtask

    // sorted ring; targets cycle through ntgt or are random below ntgt
    task automatic load_ring(int n, int ntgt, bit cyc, bit pin_ends);
        longint span;
        logic [31:0] hsh;
        span = 64'h1_0000_0000 / n;
        for (int i = 0; i < n; i++) begin
            hsh = 32'(i * span + $urandom_range(0, 32'(span - 1)));
            if (pin_ends && i == 0)
                hsh = 32'h0;
            if (pin_ends && i == n - 1)
                hsh = 32'hffff_ffff;
            load_entry(i, hsh, 4'(cyc ? i % ntgt : $urandom_range(0, ntgt - 1)));
        end
        ring_size = n;
    endtask

    // stop sending and wait until all predicted results are out
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_regs(logic [12:0] entries, logic [12:0] tcount);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RING_ENTRIES;
        cfg_data  <= entries;
        @(posedge aclk);
        cfg_index <= CFG_TARGET_COUNT;
        cfg_data  <= tcount;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one random request: mostly whole keys, some noise chunks and reloads
    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_request(OP_KEY, 12'($urandom), $urandom, 4'($urandom), $urandom,
                         3'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                         5'($urandom));
        else if (pick == 1 && ring_size > 0)
            load_entry($urandom_range(0, ring_size - 1), $urandom, 4'($urandom));
        else
            send_key($urandom_range(1, 16),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16)),
                     5'($urandom));
    endtask

    // stimulus and verdict
    initial begin
        int sizes [4] = '{1, 2, 37, 50};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty ring, various key shapes
        set_regs(13'd0, 13'd0);
        send_key(1, 16'd1, 5'd1);
        send_key(2, 16'd2, 5'd0);
        send_key(3, 16'd3, 5'd31);
        send_key(4, 16'd4, 5'd16);
        send_key(9, 16'd9, 5'd2);
        send_key(4, 16'hffff, 5'd3);
        send_key(4, 16'h0000, 5'd3);
        send_request(OP_KEY, '0, '0, '0, 32'hffff_ffff, 3'd0, 16'd5, 1'b1, 1'b0, 5'd1);
        send_request(OP_KEY, '0, '0, '0, 32'hffff_ffff, 3'd7, 16'd5, 1'b0, 1'b0, 5'd1);
        send_request(OP_KEY, '0, '0, '0, 32'hffff_ffff, 3'd5, 16'd5, 1'b0, 1'b1, 5'd1);
        // chunk without first continues the hash
        send_request(OP_KEY, '0, '0, '0, 32'h0, 3'd4, 16'd5, 1'b0, 1'b1, 5'd1);
        drain();

        // small ring, edge hashes, zero target count then clamps
        load_ring(8, 4, 1'b0, 1'b1);
        drain();
        set_regs(13'd8, 13'd0);
        send_key(4, 16'd4, 5'd4);
        drain();
        set_regs(13'd8, 13'd4);
        send_key(5, 16'd5, 5'd0);
        send_key(5, 16'd5, 5'd1);
        send_key(6, 16'd6, 5'd4);
        send_key(7, 16'd7, 5'd31);
        drain();
        // more targets claimed than present: one lap
        set_regs(13'd8, 13'd31);
        send_key(8, 16'd8, 5'd16);
        send_key(3, 16'd3, 5'd31);
        drain();

        // random phases over several ring sizes
        for (int ph = 0; ph < 4; ph++) begin
            load_ring(sizes[ph], $urandom_range(1, 16), 1'b0, ph[0]);
            drain();
            set_regs(13'(sizes[ph]),
                     ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 31))
                                                 : 13'($urandom_range(1, 16)));
            if (ph == 2) begin
                // long receiver hold while requests keep coming
                hold_seq <= hold_seq + 1;
                repeat (8) send_key(2, 16'd2, 5'd16);
            end
            repeat (10) random_request();
            drain();
        end

        // oversized target count saturates on the last ring
        set_regs(13'(ring_size), 13'd31);
        repeat (4) send_key($urandom_range(1, 8), 16'($urandom), 5'($urandom));
        send_key(4, 16'hffff, 5'd16);
        drain();
        repeat (60) @(posedge aclk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
